### rtl/core/sparse_polynomial_merge_add_core_macros.svh
// ----------------------------------------------------------------------------
// Sparse polynomial merge-add core: assertion macros
// Shared property forms for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_MERGE_ADD_CORE_MACROS_SVH
`define SPARSE_POLYNOMIAL_MERGE_ADD_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SPMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SPMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/spma_pkg.sv
// ----------------------------------------------------------------------------
// Sparse polynomial merge-add package
// Term type, action codes and sequencer states shared by the core.
// ----------------------------------------------------------------------------
package spma_pkg;

   localparam int COEF_W = 16;
   localparam int EXP_W  = 8;
   localparam int SUM_W  = 17;

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic [EXP_W-1:0]         exponent;
   } term_type;

   localparam logic [1:0] ACT_APPEND_A = 2'd0;
   localparam logic [1:0] ACT_APPEND_B = 2'd1;
   localparam logic [1:0] ACT_MERGE    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_CALC = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

endpackage

### rtl/core/sparse_polynomial_merge_add_core.sv
// Appends leave the core idle and ready, so they can be accepted back to back.
// A merge emits its terms one at a time: list read, compare and add in the shared
// unit, then the output register; the next read waits until the result is taken.
// A merge of two empty lists presents its single result in the cycle after acceptance.
// Reset is synchronous: counts, drop flag, sequencer and output valid are cleared;
// list contents are not cleared, since only entries below the counts are read.
// ----------------------------------------------------------------------------
// Sparse polynomial merge-add core
// Holds two term lists and merges them in falling exponent order, summing
// terms of equal exponent, through one shared compare and add unit.
// ----------------------------------------------------------------------------
module sparse_polynomial_merge_add_core
   import spma_pkg::*;
#(
   parameter int MAX_TERMS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] coefficient, [23:16] exponent
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [16:0] sum_coefficient, [24:17] term_exponent
   output logic [1:0]  rsp_tuser,   // [0] is_empty, [1] overflow_seen
   output logic        rsp_tlast    // last_term
);

   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CW-1:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in;
   logic dropped_ff, dropped_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [EXP_W-1:0] rsp_exp_ff, rsp_exp_in;
   logic rsp_empty_ff, rsp_empty_in;
   logic rsp_ovf_ff, rsp_ovf_in;
   logic rsp_last_ff, rsp_last_in;

   logic req_fire;
   logic wr_a, wr_b;
   term_type req_term, head_a, head_b;

   logic a_live, b_live, take_a, take_b;
   logic signed [SUM_W-1:0] op_a, op_b;
   logic [CW-1:0] idx_a_next, idx_b_next;

   assign req_term.coefficient = req_tdata[15:0];
   assign req_term.exponent    = req_tdata[23:16];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   spma_list #(.DEPTH(MAX_TERMS), .AW(AW)) u_list_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[AW-1:0]),
      .wr_term (req_term),
      .rd_addr (idx_a_ff[AW-1:0]),
      .rd_term (head_a)
   );

   spma_list #(.DEPTH(MAX_TERMS), .AW(AW)) u_list_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[AW-1:0]),
      .wr_term (req_term),
      .rd_addr (idx_b_ff[AW-1:0]),
      .rd_term (head_b)
   );

   // Shared compare and add: an exhausted list is never picked.
   always_comb begin
      a_live = (idx_a_ff < cnt_a_ff);
      b_live = (idx_b_ff < cnt_b_ff);
      take_a = a_live && (!b_live || (head_a.exponent >= head_b.exponent));
      take_b = b_live && (!a_live || (head_a.exponent <= head_b.exponent));
      op_a   = take_a ? SUM_W'(head_a.coefficient) : '0;
      op_b   = take_b ? SUM_W'(head_b.coefficient) : '0;
      idx_a_next = take_a ? idx_a_ff + CW'(1) : idx_a_ff;
      idx_b_next = take_b ? idx_b_ff + CW'(1) : idx_b_ff;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_coef_in  = rsp_coef_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      wr_a         = 1'b0;
      wr_b         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  ACT_APPEND_A: begin
                     if (cnt_a_ff == CW'(MAX_TERMS)) begin
                        dropped_in = 1'b1;
                     end else begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + CW'(1);
                     end
                  end
                  ACT_APPEND_B: begin
                     if (cnt_b_ff == CW'(MAX_TERMS)) begin
                        dropped_in = 1'b1;
                     end else begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + CW'(1);
                     end
                  end
                  ACT_MERGE: begin
                     idx_a_in = '0;
                     idx_b_in = '0;
                     if (cnt_a_ff == '0 && cnt_b_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_coef_in  = '0;
                        rsp_exp_in   = '0;
                        rsp_empty_in = 1'b1;
                        rsp_ovf_in   = dropped_ff;
                        rsp_last_in  = 1'b1;
                        state_in     = ST_HOLD;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            // The list heads are read out of the stores during this cycle.
            state_in = ST_CALC;
         end
         ST_CALC: begin
            rsp_valid_in = 1'b1;
            rsp_coef_in  = op_a + op_b;
            rsp_exp_in   = take_a ? head_a.exponent : head_b.exponent;
            rsp_empty_in = 1'b0;
            rsp_ovf_in   = dropped_ff;
            rsp_last_in  = (idx_a_next >= cnt_a_ff) && (idx_b_next >= cnt_b_ff);
            idx_a_in     = idx_a_next;
            idx_b_in     = idx_b_next;
            state_in     = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  cnt_a_in   = '0;
                  cnt_b_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coef_ff  <= rsp_coef_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_exp_ff, rsp_coef_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};
   assign rsp_tlast  = rsp_last_ff;

`include "sparse_polynomial_merge_add_core_macros.svh"

   `SPMA_ASSERT_NOW(a_idle_no_result, clock, reset, req_tready, !rsp_tvalid, "result pending while ready for input")
   `SPMA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, (cnt_a_ff <= CW'(MAX_TERMS)) && (cnt_b_ff <= CW'(MAX_TERMS)), "list count beyond capacity")
   `SPMA_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast, "empty result not marked last")
   `SPMA_ASSERT_NEXT(a_clear_after_merge, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, (cnt_a_ff == '0) && (cnt_b_ff == '0) && !dropped_ff, "lists not cleared after merge")

endmodule

### rtl/core/spma_list.sv
// ----------------------------------------------------------------------------
// Term list store
// One list of terms: single write port, single registered read port.
// ----------------------------------------------------------------------------
module spma_list
   import spma_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  term_type      wr_term,
   input  logic [AW-1:0] rd_addr,
   output term_type      rd_term
);

   term_type mem [DEPTH];
   term_type rd_term_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_term;
      end
      rd_term_ff <= mem[rd_addr];
   end

   assign rd_term = rd_term_ff;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse polynomial merge-add core testbench
// Streams term appends and merge requests into the core with bursty input
// and a stalling result side, predicts every merged term in a scoreboard
// and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import spma_pkg::*;

   localparam int         MAX_TERMS   = 16;
   localparam int         ITEM_TARGET = 300;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   typedef struct packed {
      logic [SUM_W-1:0] sum_coefficient;
      logic [EXP_W-1:0] term_exponent;
      logic             is_empty;
      logic             overflow_seen;
      logic             last_term;
   } merged_term_type;

   // Holds its own copy of both term lists and the queue of merged terms still due.
   class merge_scoreboard;
      term_type        terms_a[MAX_TERMS];
      term_type        terms_b[MAX_TERMS];
      int              count_a;
      int              count_b;
      bit              dropped;
      merged_term_type due_terms[$];
      int              errors;

      function new();
         count_a = 0;
         count_b = 0;
         dropped = 1'b0;
         errors  = 0;
      endfunction

      function int pending();
         return due_terms.size();
      endfunction

      function void push_term(int coef, int expo, bit empty, bit last);
         merged_term_type t;
         t.sum_coefficient = coef[SUM_W-1:0];
         t.term_exponent   = expo[EXP_W-1:0];
         t.is_empty        = empty;
         t.overflow_seen   = dropped;
         t.last_term       = last;
         due_terms.push_back(t);
      endfunction

      function void note_request(logic [1:0] action, term_type t);
         int i;
         int j;
         int c;
         int e;
         case (action)
            ACT_APPEND_A: begin
               if (count_a >= MAX_TERMS) dropped = 1'b1;
               else begin
                  terms_a[count_a] = t;
                  count_a++;
               end
            end
            ACT_APPEND_B: begin
               if (count_b >= MAX_TERMS) dropped = 1'b1;
               else begin
                  terms_b[count_b] = t;
                  count_b++;
               end
            end
            ACT_MERGE: begin
               if (count_a == 0 && count_b == 0) push_term(0, 0, 1'b1, 1'b1);
               else begin
                  i = 0;
                  j = 0;
                  while (i < count_a || j < count_b) begin
                     if (j >= count_b ||
                         (i < count_a && terms_a[i].exponent > terms_b[j].exponent)) begin
                        c = $signed(terms_a[i].coefficient);
                        e = terms_a[i].exponent;
                        i++;
                     end else if (i >= count_a ||
                                  terms_a[i].exponent < terms_b[j].exponent) begin
                        c = $signed(terms_b[j].coefficient);
                        e = terms_b[j].exponent;
                        j++;
                     end else begin
                        c = $signed(terms_a[i].coefficient) + $signed(terms_b[j].coefficient);
                        e = terms_a[i].exponent;
                        i++;
                        j++;
                     end
                     push_term(c, e, 1'b0, i >= count_a && j >= count_b);
                  end
               end
               count_a = 0;
               count_b = 0;
               dropped = 1'b0;
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(merged_term_type got);
         merged_term_type want;
         if (due_terms.size() == 0) begin
            report($sformatf("result with nothing outstanding (sum %0d, exponent %0d)",
                             $signed(got.sum_coefficient), got.term_exponent));
            return;
         end
         want = due_terms.pop_front();
         if (got.sum_coefficient !== want.sum_coefficient)
            report($sformatf("sum_coefficient %0d, expected %0d",
                             $signed(got.sum_coefficient), $signed(want.sum_coefficient)));
         if (got.term_exponent !== want.term_exponent)
            report($sformatf("term_exponent %0d, expected %0d",
                             got.term_exponent, want.term_exponent));
         if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
         if (got.overflow_seen !== want.overflow_seen)
            report($sformatf("overflow_seen %b, expected %b",
                             got.overflow_seen, want.overflow_seen));
         if (got.last_term !== want.last_term)
            report($sformatf("last_term %b, expected %b", got.last_term, want.last_term));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [15:0] coefficient, [23:16] exponent
   logic [1:0]  req_tuser  = '0;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [16:0] sum_coefficient, [24:17] term_exponent
   logic [1:0]  rsp_tuser;         // [0] is_empty, [1] overflow_seen
   logic        rsp_tlast;

   merge_scoreboard sb;
   int              items_sent  = 0;
   int              burst_left  = 0;
   bit              pressure_on = 1'b0;

   sparse_polynomial_merge_add_core #(
      .MAX_TERMS(MAX_TERMS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Both channels are observed at the rising edge, before the core updates.
   always @(posedge clock) begin
      merged_term_type got;
      term_type        req_term;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.sum_coefficient = rsp_tdata[16:0];
            got.term_exponent   = rsp_tdata[24:17];
            got.is_empty        = rsp_tuser[0];
            got.overflow_seen   = rsp_tuser[1];
            got.last_term       = rsp_tlast;
            sb.check_result(got);
         end
         if (req_tvalid && req_tready) begin
            req_term.coefficient = req_tdata[15:0];
            req_term.exponent    = req_tdata[23:16];
            sb.note_request(req_tuser, req_term);
         end
      end
   end

   // Result side: stall patterns that change every so often, plus one long hold-off.
   initial begin
      int  mode;
      int  mode_left;
      int  hold_left;
      bit  hold_done;
      bit  toggle;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      toggle    = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_on && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         toggle = ~toggle;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 1);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= toggle;
            endcase
         end
      end
   end

   function automatic logic [15:0] pick_coefficient();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one transaction, with a random gap at the end of each burst.
   task automatic send(input logic [1:0] action, input logic [15:0] coef,
                       input logic [7:0] expo);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {expo, coef};
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (action != ACT_IGNORED) items_sent++;
   endtask

   task automatic send_term(input logic [1:0] action, input int coef, input int expo);
      send(action, coef[15:0], expo[7:0]);
   endtask

   task automatic send_merge();
      send(ACT_MERGE, 16'($urandom), 8'($urandom));
   endtask

   // Draws a falling run of distinct exponents and shares it out between the lists,
   // some exponents landing in both, then interleaves the appends and merges.
   task automatic send_polynomials(input int pool_size);
      term_type   run_a[$];
      term_type   run_b[$];
      term_type   t;
      int         prev;
      int         e;
      int         choice;
      prev = 256;
      for (int k = 0; k < pool_size; k++) begin
         e      = $urandom_range(prev - 1, pool_size - 1 - k);
         prev   = e;
         choice = $urandom_range(0, 2);
         if (choice != 1 && run_a.size() < MAX_TERMS) begin
            t.coefficient = pick_coefficient();
            t.exponent    = e[7:0];
            run_a.push_back(t);
         end
         if (choice != 0 && run_b.size() < MAX_TERMS) begin
            t.coefficient = pick_coefficient();
            t.exponent    = e[7:0];
            run_b.push_back(t);
         end
      end
      while (run_a.size() != 0 || run_b.size() != 0) begin
         if (run_b.size() == 0 || (run_a.size() != 0 && $urandom_range(0, 1))) begin
            t = run_a.pop_front();
            send(ACT_APPEND_A, t.coefficient, t.exponent);
         end else begin
            t = run_b.pop_front();
            send(ACT_APPEND_B, t.coefficient, t.exponent);
         end
      end
      send_merge();
   endtask

   // Fills list A, list B, both or neither past capacity, so that appends may be dropped.
   task automatic send_overflow();
      int extra_a;
      int extra_b;
      extra_a = $urandom_range(0, 1) ? MAX_TERMS + $urandom_range(1, 3)
                                     : $urandom_range(0, MAX_TERMS);
      extra_b = $urandom_range(0, 1) ? MAX_TERMS + $urandom_range(1, 3)
                                     : $urandom_range(0, 4);
      for (int k = 0; k < extra_a; k++)
         send(ACT_APPEND_A, pick_coefficient(), 8'(255 - 3 * k));
      for (int k = 0; k < extra_b; k++)
         send(ACT_APPEND_B, pick_coefficient(), 8'($urandom));
      send_merge();
   endtask

   // Unordered exponents and ignored actions mixed in, closed by a merge.
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 10);
      repeat (n) send(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      send_merge();
   endtask

   // Sixteen terms in each list with interleaved exponents: the longest merge.
   task automatic send_full_lists();
      for (int k = 0; k < 2 * MAX_TERMS; k++)
         send_term((k % 2 == 0) ? ACT_APPEND_A : ACT_APPEND_B, 1000 * k - 16000, 255 - k);
      send_merge();
   endtask

   initial begin
      int r;
      int wait_cycles;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed cases.
      send_merge();                                  // both lists empty
      send_term(ACT_APPEND_A, 32767, 255);           // extreme coefficients and exponents
      send_term(ACT_APPEND_A, -32768, 0);
      send_term(ACT_APPEND_B, 32767, 255);
      send_term(ACT_APPEND_B, -32768, 0);
      send_merge();
      send_term(ACT_APPEND_A, 100, 7);               // sum of zero is still emitted
      send_term(ACT_APPEND_B, -100, 7);
      send_merge();
      send_term(ACT_APPEND_A, 1, 3);                 // only list A holds terms
      send_merge();
      send_term(ACT_APPEND_B, -1, 200);              // only list B holds terms
      send_merge();
      send_term(ACT_APPEND_A, 1, 5);                 // exponents rising within a list
      send_term(ACT_APPEND_A, 2, 9);
      send_term(ACT_APPEND_B, 3, 9);
      send_merge();
      send(ACT_IGNORED, 16'h5a5a, 8'ha5);            // ignored action leaves lists empty
      send_merge();

      // The receiver holds off while the longest merge and its followers queue up.
      pressure_on = 1'b1;
      send_full_lists();
      send_polynomials(8);
      send_overflow();

      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            if ($urandom_range(0, 99) < 85) send_polynomials($urandom_range(0, 10));
            else send_polynomials($urandom_range(11, 2 * MAX_TERMS));
         end else if (r < 82) send_overflow();
         else send_noise();
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (sb.pending() != 0 && wait_cycles < 100_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (sb.pending() != 0)
         sb.report($sformatf("%0d merged terms never arrived", sb.pending()));
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/spma_pkg.sv
rtl/core/spma_list.sv
rtl/core/sparse_polynomial_merge_add_core.sv
sim/testbench.sv
